// ----- rtl/sfdcb_pkg.sv -----
package sfdcb_pkg;

  localparam int DEPTH_DEFAULT = 64;
  localparam int SAMPLE_BITS_DEFAULT = 64;

  localparam int OP_W = 3;
  localparam int WORD_W = 64;
  localparam int CNT_W = 7;
  localparam int PTR_W = 6;
  localparam int DROP_W = 32;

  localparam int QDEPTH = 4;
  localparam int QAW = $clog2(QDEPTH);
  localparam int QCW = $clog2(QDEPTH + 1);

  typedef enum logic [OP_W-1:0] {
    OP_PUSH        = 3'd0,
    OP_POP_BATCH   = 3'd1,
    OP_CLEAR_ALL   = 3'd2,
    OP_CLEAR_DROPS = 3'd3,
    OP_ATTACH      = 3'd4,
    OP_DETACH      = 3'd5
  } op_t;

  typedef struct packed {
    logic              pop;
    logic [CNT_W-1:0]  count;
    logic [PTR_W-1:0]  ptr;
    logic [CNT_W-1:0]  stored;
    logic [DROP_W-1:0] drops;
    logic              push_dropped;
  } cmd_t;

  typedef struct packed {
    logic              en;
    logic [PTR_W-1:0]  addr;
    logic [WORD_W-1:0] data;
  } wr_t;

endpackage

// ----- rtl/sfdcb_ifs.sv -----
interface sfdcb_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  operation;
  logic [63:0] sample_in;
  logic [6:0]  max_request;

  modport source (output valid, operation, sample_in, max_request, input ready);
  modport sink (input valid, operation, sample_in, max_request, output ready);
endinterface

interface sfdcb_rsp_if;
  logic        valid;
  logic        ready;
  logic [63:0] sample_out;
  logic        sample_valid;
  logic        last;
  logic [6:0]  popped_count;
  logic [6:0]  stored_count;
  logic [31:0] drop_count;
  logic        push_dropped;

  modport source (output valid, sample_out, sample_valid, last, popped_count,
                  stored_count, drop_count, push_dropped, input ready);
  modport sink (input valid, sample_out, sample_valid, last, popped_count,
                stored_count, drop_count, push_dropped, output ready);
endinterface

// ----- rtl/sfdcb_front.sv -----
module sfdcb_front import sfdcb_pkg::*; #(
  parameter int DEPTH = DEPTH_DEFAULT,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  sfdcb_req_if.sink         req,
  output cmd_t              cmd,
  output logic              cmd_valid,
  input  logic              cmd_ready,
  output wr_t               wr,
  input  logic              rd_take
);

  localparam int AW = $clog2(DEPTH);
  localparam int FW = $clog2(DEPTH + 1);
  localparam int SW = $clog2(2 * DEPTH);

  logic [AW-1:0]     wp, wp_next;
  logic [AW-1:0]     rp, rp_next;
  logic [FW-1:0]     fill, fill_next;
  logic [DROP_W-1:0] drops, drops_next;
  logic              attached, attached_next;
  logic [FW-1:0]     pending, pending_next;

  logic              accept;
  logic              dropped_now;
  logic [CNT_W-1:0]  req_n;
  logic [FW-1:0]     n;
  logic [SW-1:0]     rp_sum;
  op_t               op;

  assign op = op_t'(req.operation);
  assign req.ready = cmd_ready && (pending == '0 || op != OP_PUSH);
  assign accept = req.valid && req.ready;

  always_comb begin
    if (!attached) begin
      req_n = '0;
    end else if (CNT_W'(fill) < req.max_request) begin
      req_n = CNT_W'(fill);
    end else begin
      req_n = req.max_request;
    end
  end

  assign n = req_n[FW-1:0];
  assign rp_sum = SW'(rp) + SW'(n);

  always_comb begin
    wp_next = wp;
    rp_next = rp;
    fill_next = fill;
    drops_next = drops;
    attached_next = attached;
    dropped_now = 1'b0;
    wr.en = 1'b0;
    wr.addr = PTR_W'(wp);
    wr.data = WORD_W'(req.sample_in[SAMPLE_BITS-1:0]);
    unique case (op)
      OP_PUSH: begin
        if (attached) begin
          if (fill == FW'(DEPTH)) begin
            dropped_now = 1'b1;
            if (drops != '1) begin
              drops_next = drops + 1'b1;
            end
          end else begin
            wr.en = accept;
            wp_next = (wp == AW'(DEPTH - 1)) ? '0 : wp + 1'b1;
            fill_next = fill + 1'b1;
          end
        end
      end
      OP_POP_BATCH: begin
        rp_next = (rp_sum >= SW'(DEPTH)) ? AW'(rp_sum - SW'(DEPTH)) : AW'(rp_sum);
        fill_next = fill - n;
      end
      OP_CLEAR_ALL, OP_ATTACH, OP_DETACH: begin
        wp_next = '0;
        rp_next = '0;
        fill_next = '0;
        drops_next = '0;
        if (op == OP_ATTACH) begin
          attached_next = 1'b1;
        end else if (op == OP_DETACH) begin
          attached_next = 1'b0;
        end
      end
      OP_CLEAR_DROPS: begin
        drops_next = '0;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    pending_next = pending;
    if (accept && op == OP_POP_BATCH) begin
      pending_next = pending_next + n;
    end
    if (rd_take) begin
      pending_next = pending_next - 1'b1;
    end
  end

  assign cmd_valid = accept;
  assign cmd.pop = (op == OP_POP_BATCH) && (n != '0);
  assign cmd.count = cmd.pop ? CNT_W'(n) : '0;
  assign cmd.ptr = PTR_W'(rp);
  assign cmd.stored = CNT_W'(fill_next);
  assign cmd.drops = drops_next;
  assign cmd.push_dropped = dropped_now;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      fill <= '0;
      drops <= '0;
      attached <= 1'b0;
      pending <= '0;
    end else begin
      pending <= pending_next;
      if (accept) begin
        wp <= wp_next;
        rp <= rp_next;
        fill <= fill_next;
        drops <= drops_next;
        attached <= attached_next;
      end
    end
  end

endmodule

// ----- rtl/sfdcb_queue.sv -----
module sfdcb_queue import sfdcb_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  cmd_t in_cmd,
  input  logic in_valid,
  output logic in_ready,
  output cmd_t out_cmd,
  output logic out_valid,
  input  logic out_ready
);

  cmd_t           entries [QDEPTH];
  logic [QAW-1:0] head;
  logic [QAW-1:0] tail;
  logic [QCW-1:0] count;
  logic           push;
  logic           pop;

  assign in_ready = (count != QCW'(QDEPTH));
  assign out_valid = (count != '0);
  assign out_cmd = entries[head];
  assign push = in_valid && in_ready;
  assign pop = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[tail] <= in_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      tail <= '0;
      count <= '0;
    end else begin
      if (push) begin
        tail <= tail + 1'b1;
      end
      if (pop) begin
        head <= head + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/sfdcb_back.sv -----
module sfdcb_back import sfdcb_pkg::*; #(
  parameter int DEPTH = DEPTH_DEFAULT,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        q_cmd,
  input  logic        q_valid,
  output logic        q_ready,
  input  wr_t         wr,
  output logic        rd_take,
  sfdcb_rsp_if.source rsp
);

  localparam int AW = $clog2(DEPTH);

  logic [SAMPLE_BITS-1:0] mem [DEPTH];
  logic [SAMPLE_BITS-1:0] rd_data;

  logic             cur_valid;
  cmd_t             cur_cmd;
  logic [CNT_W-1:0] cur_left;

  logic             src_valid;
  cmd_t             src;
  cmd_t             src_adv;
  logic [CNT_W-1:0] src_left;
  logic [AW-1:0]    src_addr;
  logic [AW-1:0]    src_addr_inc;

  logic             rd_pend;
  logic             m_valid;
  logic             m_last;
  logic [CNT_W-1:0] m_popped;
  logic [CNT_W-1:0] m_stored;
  logic [DROP_W-1:0] m_drops;
  logic             m_push_dropped;

  logic             out_load;
  logic             issue;

  assign src_valid = cur_valid || q_valid;
  assign src = cur_valid ? cur_cmd : q_cmd;
  assign src_left = cur_valid ? cur_left : q_cmd.count;
  assign src_addr = src.ptr[AW-1:0];
  assign src_addr_inc = (src_addr == AW'(DEPTH - 1)) ? '0 : src_addr + 1'b1;

  always_comb begin
    src_adv = src;
    src_adv.ptr = PTR_W'(src_addr_inc);
  end

  assign out_load = rd_pend && (!rsp.valid || rsp.ready);
  assign issue = src_valid && (!rd_pend || out_load);
  assign q_ready = issue && !cur_valid;
  assign rd_take = issue && src.pop;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr[AW-1:0]] <= wr.data[SAMPLE_BITS-1:0];
    end
    if (issue) begin
      rd_data <= mem[src_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      cur_cmd <= src_adv;
      cur_left <= src_left - 1'b1;
      m_valid <= src.pop;
      m_last <= !src.pop || (src_left == CNT_W'(1));
      m_popped <= src.count;
      m_stored <= src.stored;
      m_drops <= src.drops;
      m_push_dropped <= src.push_dropped;
    end
    if (out_load) begin
      rsp.sample_out <= m_valid ? WORD_W'(rd_data) : '0;
      rsp.sample_valid <= m_valid;
      rsp.last <= m_last;
      rsp.popped_count <= m_popped;
      rsp.stored_count <= m_stored;
      rsp.drop_count <= m_drops;
      rsp.push_dropped <= m_push_dropped;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      rd_pend <= 1'b0;
      rsp.valid <= 1'b0;
    end else begin
      if (issue) begin
        cur_valid <= src.pop && (src_left > CNT_W'(1));
        rd_pend <= 1'b1;
      end else if (out_load) begin
        rd_pend <= 1'b0;
      end
      if (out_load) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

endmodule

// ----- rtl/sample_fifo_drop_count_batch_pop_unit.sv -----
// Sample FIFO with drop counting and batch pop.
// The req channel carries one operation per transaction: push, pop batch,
// clear all, clear drops, attach or detach. The rsp channel returns the
// results: one status transaction for every operation, or, for a pop batch
// that finds samples, one transaction per popped sample with last set on the
// final one. Every result reports the fill level and the saturating drop count
// as they stand after the operation.
// A front stage accepts and classifies operations and updates pointers, fill
// level and drop count at once; a four-entry command queue feeds a back stage
// that reads the sample memory and drives a registered output.
// Each result passes through the command queue, the read stage registers and
// the output register. Operations are taken one per cycle while the queue has
// room, and a pop batch returns one result per sample, one per cycle while
// rsp.ready stays high. A push waits while samples of an earlier pop batch are
// still to be read from memory, as its write could land in an unread slot.
// When the receiver stalls, results hold in the output register and the
// command queue fills; once it is full, req.ready falls.
// Reset empties the queue and the output, zeroes pointers, fill level and drop
// count, and leaves the store detached. The memory itself is not cleared.
module sample_fifo_drop_count_batch_pop_unit import sfdcb_pkg::*; #(
  parameter int DEPTH = DEPTH_DEFAULT,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  sfdcb_req_if.sink   req,
  sfdcb_rsp_if.source rsp
);

  cmd_t f_cmd;
  logic f_valid;
  logic f_ready;
  cmd_t q_cmd;
  logic q_valid;
  logic q_ready;
  wr_t  wr;
  logic rd_take;

  sfdcb_front #(
    .DEPTH(DEPTH),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .req(req),
    .cmd(f_cmd),
    .cmd_valid(f_valid),
    .cmd_ready(f_ready),
    .wr(wr),
    .rd_take(rd_take)
  );

  sfdcb_queue u_queue (
    .clk(clk),
    .rst(rst),
    .in_cmd(f_cmd),
    .in_valid(f_valid),
    .in_ready(f_ready),
    .out_cmd(q_cmd),
    .out_valid(q_valid),
    .out_ready(q_ready)
  );

  sfdcb_back #(
    .DEPTH(DEPTH),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .q_cmd(q_cmd),
    .q_valid(q_valid),
    .q_ready(q_ready),
    .wr(wr),
    .rd_take(rd_take),
    .rsp(rsp)
  );

endmodule
